### rtl/hvt_pkg.sv
// hvt_pkg: shared widths, operation codes and stage counts of the
// homogeneous vertex transform. It depends on nothing.
package hvt_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_W     = 2 * DATA_WIDTH;        // exact product
  localparam int SUM_W      = PROD_W + 2;            // sum of four products
  localparam int NUM_W      = DATA_WIDTH + FRAC_BITS; // dividend magnitude
  localparam int COL_STAGES = 3;                     // multiply, sum, round
  localparam int DIV_STAGES = NUM_W + 1;             // prepare + one bit each
  localparam int NSTAGE     = COL_STAGES + DIV_STAGES + 1;
  localparam int LANES      = 3;

  typedef logic signed [DATA_WIDTH-1:0] fix_t;

  localparam fix_t FIX_ONE = fix_t'(1) <<< FRAC_BITS;
  localparam fix_t FIX_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam fix_t FIX_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [15:0] DIAG_MASK = 16'h8421;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_POINT  = 2'd1,
    OP_NORMAL = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef struct packed {
    logic point;
    logic wz;
  } side_t;

endpackage

### rtl/hvt_if.sv
// hvt_in_if / hvt_out_if: valid-ready channels of the vertex transform.
// Depends on hvt_pkg.
interface hvt_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       operation;
  logic [1:0]                       element_row;
  logic [1:0]                       element_col;
  logic signed [hvt_pkg::DATA_WIDTH-1:0] element_value;
  logic signed [hvt_pkg::DATA_WIDTH-1:0] in_x;
  logic signed [hvt_pkg::DATA_WIDTH-1:0] in_y;
  logic signed [hvt_pkg::DATA_WIDTH-1:0] in_z;

  modport source(output valid, operation, element_row, element_col, element_value,
                 in_x, in_y, in_z, input ready);
  modport sink(input valid, operation, element_row, element_col, element_value,
               in_x, in_y, in_z, output ready);
endinterface

interface hvt_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [hvt_pkg::DATA_WIDTH-1:0] out_x;
  logic signed [hvt_pkg::DATA_WIDTH-1:0] out_y;
  logic signed [hvt_pkg::DATA_WIDTH-1:0] out_z;
  logic                             w_zero;

  modport source(output valid, out_x, out_y, out_z, w_zero, input ready);
  modport sink(input valid, out_x, out_y, out_z, w_zero, output ready);
endinterface

### rtl/hvt_col_lane.sv
// hvt_col_lane: one matrix column times the input vector, three stages:
// products, exact sum, floor shift with saturation. Depends on hvt_pkg.
module hvt_col_lane (
  input  logic                                clk,
  input  logic [hvt_pkg::COL_STAGES-1:0]      adv,
  input  hvt_pkg::fix_t                       vx,
  input  hvt_pkg::fix_t                       vy,
  input  hvt_pkg::fix_t                       vz,
  input  hvt_pkg::fix_t                       m_r0,
  input  hvt_pkg::fix_t                       m_r1,
  input  hvt_pkg::fix_t                       m_r2,
  input  hvt_pkg::fix_t                       m_t,
  input  logic                                with_one,
  output hvt_pkg::fix_t                       col
);

  localparam int DW = hvt_pkg::DATA_WIDTH;
  localparam int FB = hvt_pkg::FRAC_BITS;
  localparam int PW = hvt_pkg::PROD_W;
  localparam int SW = hvt_pkg::SUM_W;

  logic signed [PW-1:0] p0, p1, p2;
  hvt_pkg::fix_t        t;
  logic signed [SW-1:0] sum, sum_next;
  logic [SW-FB-1:0]     fl;
  logic                 fits;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p0 <= vx * m_r0;
      p1 <= vy * m_r1;
      p2 <= vz * m_r2;
      t  <= with_one ? m_t : '0;
    end
  end

  always_comb begin
    sum_next = {{2{p0[PW-1]}}, p0} + {{2{p1[PW-1]}}, p1} + {{2{p2[PW-1]}}, p2}
             + {{(SW-DW-FB){t[DW-1]}}, t, {FB{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sum <= sum_next;
    end
  end

  // dropping the fraction bits is the floor shift
  assign fl   = sum[SW-1:FB];
  assign fits = (&fl[SW-FB-1:DW-1]) || !(|fl[SW-FB-1:DW-1]);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      if (fits) begin
        col <= fl[DW-1:0];
      end else begin
        col <= fl[SW-FB-1] ? hvt_pkg::FIX_MIN : hvt_pkg::FIX_MAX;
      end
    end
  end

endmodule

### rtl/hvt_div_lane.sv
// hvt_div_lane: pipelined restoring divider, one quotient bit a stage,
// on magnitudes; carries the undivided value alongside. Depends on hvt_pkg.
module hvt_div_lane (
  input  logic                               clk,
  input  logic [hvt_pkg::DIV_STAGES-1:0]     adv,
  input  hvt_pkg::fix_t                      num,
  input  hvt_pkg::fix_t                      den,
  output logic [hvt_pkg::NUM_W-1:0]          quo,
  output logic                               neg,
  output hvt_pkg::fix_t                      pass
);

  localparam int DW = hvt_pkg::DATA_WIDTH;
  localparam int FB = hvt_pkg::FRAC_BITS;
  localparam int NW = hvt_pkg::NUM_W;
  localparam int DS = hvt_pkg::DIV_STAGES;

  logic [NW-1:0]  numq      [DS];
  logic [DW-1:0]  rem       [DS-1];
  logic [DW-1:0]  dv        [DS-1];
  logic           sgn       [DS];
  hvt_pkg::fix_t  carry     [DS];
  logic [NW-1:0]  numq_next [DS-1];
  logic [DW-1:0]  rem_next  [DS-1];
  logic [DW:0]    trial     [DS-1];
  logic [DW-1:0]  abs_num, abs_den;

  assign abs_num = num[DW-1] ? DW'(-num) : DW'(num);
  assign abs_den = den[DW-1] ? DW'(-den) : DW'(den);

  always_comb begin
    for (int k = 0; k < DS-1; k++) begin
      trial[k] = {rem[k], numq[k][NW-1]};
      if (trial[k] >= {1'b0, dv[k]}) begin
        rem_next[k] = DW'(trial[k] - {1'b0, dv[k]});
        numq_next[k] = {numq[k][NW-2:0], 1'b1};
      end else begin
        rem_next[k] = trial[k][DW-1:0];
        numq_next[k] = {numq[k][NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      numq[0]  <= {abs_num, {FB{1'b0}}};
      rem[0]   <= '0;
      dv[0]    <= abs_den;
      sgn[0]   <= num[DW-1] ^ den[DW-1];
      carry[0] <= num;
    end
    for (int k = 1; k < DS; k++) begin
      if (adv[k]) begin
        numq[k]  <= numq_next[k-1];
        sgn[k]   <= sgn[k-1];
        carry[k] <= carry[k-1];
      end
    end
    for (int k = 1; k < DS-1; k++) begin
      if (adv[k]) begin
        rem[k]   <= rem_next[k-1];
        dv[k]    <= dv[k-1];
      end
    end
  end

  assign quo  = numq[DS-1];
  assign neg  = sgn[DS-1];
  assign pass = carry[DS-1];

endmodule

### rtl/hvt_merge.sv
// hvt_merge: output stage; combines the three lanes into one result,
// applying sign, saturation and the zero-w rule. Depends on hvt_pkg.
module hvt_merge (
  input  logic                                   clk,
  input  logic                                   adv,
  input  hvt_pkg::side_t                         side,
  input  logic [hvt_pkg::NUM_W-1:0]              quo  [hvt_pkg::LANES],
  input  logic                                   neg  [hvt_pkg::LANES],
  input  hvt_pkg::fix_t                          pass [hvt_pkg::LANES],
  output hvt_pkg::fix_t                          res  [hvt_pkg::LANES],
  output logic                                   w_zero
);

  localparam int DW = hvt_pkg::DATA_WIDTH;
  localparam int NW = hvt_pkg::NUM_W;

  function automatic hvt_pkg::fix_t signed_sat(input logic [NW-1:0] q, input logic n);
    logic ov;
    begin
      if (n) begin
        ov = (|q[NW-1:DW]) || (q[DW-1] && (|q[DW-2:0]));
        signed_sat = ov ? hvt_pkg::FIX_MIN : (~q[DW-1:0]) + 1'b1;
      end else begin
        ov = |q[NW-1:DW-1];
        signed_sat = ov ? hvt_pkg::FIX_MAX : q[DW-1:0];
      end
    end
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < hvt_pkg::LANES; i++) begin
        if (!side.point) begin
          res[i] <= pass[i];
        end else if (side.wz) begin
          res[i] <= '0;
        end else begin
          res[i] <= signed_sat(quo[i], neg[i]);
        end
      end
      w_zero <= side.point && side.wz;
    end
  end

endmodule

### rtl/homogeneous_vertex_transform_top.sv
// homogeneous_vertex_transform_top: 4x4 row-vector transform with
// perspective divide. Depends on hvt_pkg, hvt_if, hvt_col_lane,
// hvt_div_lane and hvt_merge.
//
// One item is taken per clock while vin.ready is high. A load item writes one
// matrix entry at the transfer and the very next item already sees it; it
// gives no result, nor does operation three. Point and normal items each pass
// through NSTAGE = 3 + (DATA_WIDTH + FRAC_BITS + 1) + 1 register stages (53 at
// Q16.16): four column lanes multiply and sum in three stages, three divider
// lanes then retire one quotient bit per stage, and a merge stage applies
// sign, saturation and the zero-w rule. The depth is set by the divider. Every
// stage holds its own valid bit and moves when the output is taken or some
// stage from it to the output is empty, so bubbles close up and input keeps
// flowing while a finished result waits on the output, until every stage is
// full. Normal items ride through the divider unchanged; a point item whose
// rounded w is zero returns zeros with w_zero set. The matrix resets to
// identity. Coordinates, matrix entries and results are Q16.16.
module homogeneous_vertex_transform_top (
  input  logic         clk,
  input  logic         rst,
  hvt_in_if.sink       vin,
  hvt_out_if.source    vout
);

  localparam int NS = hvt_pkg::NSTAGE;
  localparam int CS = hvt_pkg::COL_STAGES;
  localparam int DS = hvt_pkg::DIV_STAGES;
  localparam int NW = hvt_pkg::NUM_W;

  hvt_pkg::fix_t  mat [16];
  logic [NS-1:0]  valid;
  logic [NS-1:0]  adv;
  hvt_pkg::side_t side [NS];
  logic           take, is_point, is_normal;
  hvt_pkg::fix_t  col  [4];
  logic [NW-1:0]  quo  [hvt_pkg::LANES];
  logic           neg  [hvt_pkg::LANES];
  hvt_pkg::fix_t  pass [hvt_pkg::LANES];
  hvt_pkg::fix_t  res  [hvt_pkg::LANES];

  // a stage advances when the output is taken or any stage from it down is empty
  for (genvar k = 0; k < NS; k++) begin : g_adv
    assign adv[k] = vout.ready || !(&valid[NS-1:k]);
  end

  assign vin.ready = adv[0];
  assign take      = vin.valid && vin.ready;
  assign is_point  = vin.operation == hvt_pkg::OP_POINT;
  assign is_normal = vin.operation == hvt_pkg::OP_NORMAL;

  // matrix: write on a load transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        mat[i] <= hvt_pkg::DIAG_MASK[i] ? hvt_pkg::FIX_ONE : '0;
      end
    end else if (take && vin.operation == hvt_pkg::OP_LOAD) begin
      mat[{vin.element_row, vin.element_col}] <= vin.element_value;
    end
  end

  // stage valids: only point and normal items enter
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[0]) begin
        valid[0] <= take && (is_point || is_normal);
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // sideband: item kind, and the zero-w flag once w is known
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      side[0] <= '{point: is_point, wz: 1'b0};
    end
    for (int k = 1; k < NS; k++) begin
      if (adv[k]) begin
        side[k].point <= side[k-1].point;
        side[k].wz    <= (k == CS) ? (side[k-1].point && (col[3] == '0))
                                   : side[k-1].wz;
      end
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_col
    hvt_col_lane u_col (
      .clk      (clk),
      .adv      (adv[CS-1:0]),
      .vx       (vin.in_x),
      .vy       (vin.in_y),
      .vz       (vin.in_z),
      .m_r0     (mat[c]),
      .m_r1     (mat[4 + c]),
      .m_r2     (mat[8 + c]),
      .m_t      (mat[12 + c]),
      .with_one (is_point),
      .col      (col[c])
    );
  end

  for (genvar c = 0; c < hvt_pkg::LANES; c++) begin : g_div
    hvt_div_lane u_div (
      .clk  (clk),
      .adv  (adv[CS +: DS]),
      .num  (col[c]),
      .den  (col[3]),
      .quo  (quo[c]),
      .neg  (neg[c]),
      .pass (pass[c])
    );
  end

  hvt_merge u_merge (
    .clk    (clk),
    .adv    (adv[NS-1]),
    .side   (side[NS-2]),
    .quo    (quo),
    .neg    (neg),
    .pass   (pass),
    .res    (res),
    .w_zero (vout.w_zero)
  );

  assign vout.valid = valid[NS-1];
  assign vout.out_x = res[0];
  assign vout.out_y = res[1];
  assign vout.out_z = res[2];

endmodule

### rtl/hvt_check.sv
// hvt_check: port-level assertions for the vertex transform, and the bind
// that attaches them to homogeneous_vertex_transform_top. Depends on hvt_pkg.
module hvt_check (
  input logic          clk,
  input logic          rst,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input hvt_pkg::fix_t out_x,
  input hvt_pkg::fix_t out_y,
  input hvt_pkg::fix_t out_z,
  input logic          w_zero
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z)
                                && $stable(w_zero))
    else $error("stalled result changed");

  // a zero w gives a zero vector
  a_wz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && w_zero |-> out_x == '0 && out_y == '0 && out_z == '0)
    else $error("w_zero with nonzero output");

  // nothing leaves right after reset, and input is open then
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind homogeneous_vertex_transform_top hvt_check u_hvt_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (vin.ready),
  .out_valid (vout.valid),
  .out_ready (vout.ready),
  .out_x     (vout.out_x),
  .out_y     (vout.out_y),
  .out_z     (vout.out_z),
  .w_zero    (vout.w_zero)
);

### bench/tb.sv
// tb: self-checking bench for homogeneous_vertex_transform_top.
// Depends on hvt_pkg and hvt_if; predicts each result and compares it in order.
module tb;

  // Pipeline depth in stages (53 at Q16.16)
  localparam int LATENCY = hvt_pkg::NSTAGE;

  typedef struct {
    hvt_pkg::fix_t x;
    hvt_pkg::fix_t y;
    hvt_pkg::fix_t z;
    logic wz;
  } vec_result_t;

  logic clk;
  logic rst;
  hvt_in_if  vin();
  hvt_out_if vout();

  homogeneous_vertex_transform_top i_dut (
    .clk  (clk),
    .rst  (rst),
    .vin  (vin.sink),
    .vout (vout.source)
  );

  // Shadow copy of the matrix, index row*4+col
  hvt_pkg::fix_t shadow_matrix[16];
  vec_result_t   expected_results[$];
  int            error_count;
  bit            sink_stall_enable;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Column sum of products: exact sum, floor shift by FRAC_BITS, saturate.
  // The 32x32 products and a sum of four fit comfortably in 96 bits.
  function automatic hvt_pkg::fix_t column_sum(hvt_pkg::fix_t vx, hvt_pkg::fix_t vy,
                                               hvt_pkg::fix_t vz, int col,
                                               bit with_one);
    logic signed [95:0] acc;
    logic signed [95:0] shifted;
    acc = 96'(signed'(vx)) * 96'(signed'(shadow_matrix[col]))
        + 96'(signed'(vy)) * 96'(signed'(shadow_matrix[4 + col]))
        + 96'(signed'(vz)) * 96'(signed'(shadow_matrix[8 + col]));
    if (with_one)
      acc = acc + (96'(signed'(shadow_matrix[12 + col])) <<< hvt_pkg::FRAC_BITS);
    shifted = acc >>> hvt_pkg::FRAC_BITS;
    if (shifted > 96'(signed'(hvt_pkg::FIX_MAX))) return hvt_pkg::FIX_MAX;
    if (shifted < 96'(signed'(hvt_pkg::FIX_MIN))) return hvt_pkg::FIX_MIN;
    return hvt_pkg::fix_t'(shifted);
  endfunction

  // Perspective divide: (num << FRAC_BITS) / w, truncated, saturated
  function automatic hvt_pkg::fix_t perspective_div(hvt_pkg::fix_t num, hvt_pkg::fix_t w);
    logic signed [95:0] dividend;
    logic signed [95:0] quot;
    dividend = 96'(signed'(num)) <<< hvt_pkg::FRAC_BITS;
    quot = dividend / 96'(signed'(w));
    if (quot > 96'(signed'(hvt_pkg::FIX_MAX))) return hvt_pkg::FIX_MAX;
    if (quot < 96'(signed'(hvt_pkg::FIX_MIN))) return hvt_pkg::FIX_MIN;
    return hvt_pkg::fix_t'(quot);
  endfunction

  // Update the shadow matrix or queue the expected vector for one transfer
  function automatic void predict_transform(logic [1:0] op, logic [1:0] row,
                                            logic [1:0] col, hvt_pkg::fix_t value,
                                            hvt_pkg::fix_t vx, hvt_pkg::fix_t vy,
                                            hvt_pkg::fix_t vz);
    vec_result_t r;
    hvt_pkg::fix_t w;
    r.wz = 1'b0;
    case (op)
      hvt_pkg::OP_LOAD: begin
        shadow_matrix[{row, col}] = value;
        return;
      end
      hvt_pkg::OP_POINT: begin
        w = column_sum(vx, vy, vz, 3, 1'b1);
        if (w == 0) begin
          r.wz = 1'b1;
          r.x = '0; r.y = '0; r.z = '0;
        end else begin
          r.x = perspective_div(column_sum(vx, vy, vz, 0, 1'b1), w);
          r.y = perspective_div(column_sum(vx, vy, vz, 1, 1'b1), w);
          r.z = perspective_div(column_sum(vx, vy, vz, 2, 1'b1), w);
        end
      end
      hvt_pkg::OP_NORMAL: begin
        r.x = column_sum(vx, vy, vz, 0, 1'b0);
        r.y = column_sum(vx, vy, vz, 1, 1'b0);
        r.z = column_sum(vx, vy, vz, 2, 1'b0);
      end
      default: return;  // operation three: dropped by the block
    endcase
    expected_results.push_back(r);
  endfunction

  // Drive one item, hold it until the transfer, optionally idle first
  task automatic send_item(logic [1:0] op, logic [1:0] row, logic [1:0] col,
                           hvt_pkg::fix_t value, hvt_pkg::fix_t vx,
                           hvt_pkg::fix_t vy, hvt_pkg::fix_t vz,
                           bit allow_gap);
    int gap;
    if (allow_gap && ($urandom_range(0, 3) == 0)) begin
      gap = $urandom_range(1, 9);
      vin.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vin.valid         <= 1'b1;
    vin.operation     <= op;
    vin.element_row   <= row;
    vin.element_col   <= col;
    vin.element_value <= value;
    vin.in_x          <= vx;
    vin.in_y          <= vy;
    vin.in_z          <= vz;
    do @(posedge clk); while (!vin.ready);
    predict_transform(op, row, col, value, vx, vy, vz);
  endtask

  task automatic load_element(int row, int col, hvt_pkg::fix_t value, bit allow_gap);
    send_item(hvt_pkg::OP_LOAD, 2'(row), 2'(col), value, '0, '0, '0, allow_gap);
  endtask

  // Drop valid and wait for the pipeline to drain completely
  task automatic drain_pipeline();
    vin.valid <= 1'b0;
    @(posedge clk);
    wait (expected_results.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic hvt_pkg::fix_t rand_fix();
    case ($urandom_range(0, 5))
      0:       return hvt_pkg::FIX_MAX;
      1:       return hvt_pkg::FIX_MIN;
      2:       return hvt_pkg::fix_t'($urandom_range(0, 32'h0004_0000))
                      - hvt_pkg::FIX_ONE * 2;
      3:       return hvt_pkg::fix_t'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      default: return hvt_pkg::fix_t'($urandom);
    endcase
  endfunction

  // Identity matrix: outputs must equal the inputs, extremes included
  task automatic test_identity();
    send_item(hvt_pkg::OP_POINT, 2'd0, 2'd0, '0, hvt_pkg::FIX_ONE,
              hvt_pkg::FIX_ONE * 2, -hvt_pkg::FIX_ONE, 1'b0);
    send_item(hvt_pkg::OP_POINT, 2'd0, 2'd0, '0, hvt_pkg::FIX_MAX, hvt_pkg::FIX_MIN,
              32'sh0000_0001, 1'b0);
    send_item(hvt_pkg::OP_NORMAL, 2'd0, 2'd0, '0, hvt_pkg::FIX_MAX, hvt_pkg::FIX_MIN,
              32'shffff_ffff, 1'b0);
    send_item(hvt_pkg::OP_NORMAL, 2'd3, 2'd3, '0, 32'sh5555_aaaa, 32'shaaaa_5555,
              '0, 1'b0);
    send_item(hvt_pkg::OP_NOP, 2'd3, 2'd3, hvt_pkg::FIX_MAX, hvt_pkg::FIX_MAX,
              hvt_pkg::FIX_MAX, hvt_pkg::FIX_MAX, 1'b0);
    drain_pipeline();
  endtask

  // Zero w, near-zero w from rounding, saturating products and divides
  task automatic test_special_cases();
    load_element(3, 3, '0, 1'b0);               // w becomes z*m23
    send_item(hvt_pkg::OP_POINT, 2'd0, 2'd0, '0, hvt_pkg::FIX_ONE, hvt_pkg::FIX_ONE,
              '0, 1'b0);  // w is zero
    load_element(2, 3, 32'sh0000_0001, 1'b0);
    send_item(hvt_pkg::OP_POINT, 2'd0, 2'd0, '0, hvt_pkg::FIX_ONE, hvt_pkg::FIX_ONE,
              32'sh0000_ffff, 1'b0);  // rounds to 0
    send_item(hvt_pkg::OP_POINT, 2'd0, 2'd0, '0, hvt_pkg::FIX_ONE, hvt_pkg::FIX_ONE,
              -32'sh0000_0001, 1'b0); // floors to -1
    send_item(hvt_pkg::OP_POINT, 2'd0, 2'd0, '0, hvt_pkg::FIX_MAX, hvt_pkg::FIX_MIN,
              32'sh0001_0000, 1'b0);
    load_element(0, 0, hvt_pkg::FIX_MAX, 1'b0);
    load_element(1, 1, hvt_pkg::FIX_MIN, 1'b0);
    send_item(hvt_pkg::OP_NORMAL, 2'd0, 2'd0, '0, hvt_pkg::FIX_MAX, hvt_pkg::FIX_MIN,
              hvt_pkg::FIX_MAX, 1'b0);
    send_item(hvt_pkg::OP_NORMAL, 2'd0, 2'd0, '0, hvt_pkg::FIX_MIN, hvt_pkg::FIX_MAX,
              hvt_pkg::FIX_MIN, 1'b0);
    send_item(hvt_pkg::OP_POINT, 2'd0, 2'd0, '0, hvt_pkg::FIX_MIN, hvt_pkg::FIX_MIN,
              hvt_pkg::FIX_MAX, 1'b0);
    load_element(3, 0, hvt_pkg::FIX_MIN, 1'b0);
    load_element(3, 3, hvt_pkg::FIX_MAX, 1'b0);
    send_item(hvt_pkg::OP_POINT, 2'd0, 2'd0, '0, '0, '0, '0, 1'b0);
    drain_pipeline();  // sender holds off until every result has come back
  endtask

  // Random matrix loads interleaved with random vectors; no gaps in the final stretch
  task automatic test_random_stream(int n_items, bit allow_gap);
    int k;
    logic [1:0] op;
    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 9) < 2)
        op = hvt_pkg::OP_LOAD;
      else if ($urandom_range(0, 19) == 0)
        op = hvt_pkg::OP_NOP;
      else
        op = $urandom_range(0, 2) == 0 ? hvt_pkg::OP_NORMAL : hvt_pkg::OP_POINT;
      send_item(op, 2'($urandom), 2'($urandom), rand_fix(), rand_fix(), rand_fix(),
                rand_fix(), allow_gap);
    end
  endtask

  // Sink side: random stall bursts while enabled
  initial begin : sink_stall
    int burst;
    vout.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (sink_stall_enable && ($urandom_range(0, 5) == 0)) begin
        burst = $urandom_range(1, 9);
        vout.ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end
      vout.ready <= 1'b1;
    end
  end

  // Compare each transfer on the output against the oldest expectation
  always @(posedge clk) begin
    vec_result_t e;
    if (!rst && vout.valid && vout.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result x=%0d y=%0d z=%0d", vout.out_x, vout.out_y, vout.out_z);
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (vout.out_x !== e.x) begin
          $error("out_x expected %0d actual %0d", e.x, vout.out_x);
          error_count++;
        end
        if (vout.out_y !== e.y) begin
          $error("out_y expected %0d actual %0d", e.y, vout.out_y);
          error_count++;
        end
        if (vout.out_z !== e.z) begin
          $error("out_z expected %0d actual %0d", e.z, vout.out_z);
          error_count++;
        end
        if (vout.w_zero !== e.wz) begin
          $error("w_zero expected %0b actual %0b", e.wz, vout.w_zero);
          error_count++;
        end
      end
    end
  end

  // Sequence the tests
  initial begin
    int i;
    error_count       = 0;
    sink_stall_enable = 1'b0;
    for (i = 0; i < 16; i++)
      shadow_matrix[i] = hvt_pkg::DIAG_MASK[i] ? hvt_pkg::FIX_ONE : '0;
    rst               = 1'b1;
    vin.valid         <= 1'b0;
    vin.operation     <= hvt_pkg::OP_LOAD;
    vin.element_row   <= '0;
    vin.element_col   <= '0;
    vin.element_value <= '0;
    vin.in_x          <= '0;
    vin.in_y          <= '0;
    vin.in_z          <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_identity();
    test_special_cases();
    sink_stall_enable = 1'b1;
    test_random_stream(400, 1'b1);
    sink_stall_enable = 1'b0;
    test_random_stream(100, 1'b0);
    drain_pipeline();

    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Watchdog: well beyond the slowest legal run
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
